[hdl/drp_pkg.sv]
// drp_pkg: shared types and constants for the dns record parser
// holds field widths, result codes and the controller/datapath command and status structs
// no dependencies

package drp_pkg;

    // default sizes, handed down from the top level
    localparam int PACKET_BYTES_DEF = 512;
    localparam int NAME_LIMIT_DEF   = 256;
    localparam int MAX_HOPS_DEF     = 16;

    // channel widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 176;

    // internal widths
    localparam int POS_W   = 16;
    localparam int LIM_W   = 10;
    localparam int START_W = 9;
    localparam int TOTAL_W = 11;
    localparam int SUM_W   = 12;
    localparam int CNT_W   = 8;

    // byte codes of the wire format
    localparam logic [7:0] PTR_FLAGS     = 8'hc0;
    localparam logic [7:0] PTR_HIGH_MASK = 8'h3f;
    localparam logic [7:0] DOT_CHAR      = 8'h2e;
    localparam int         FIXED_PART    = 10;
    localparam int         CHUNK_BYTES   = 8;

    // input action selector
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PARSE = 1'b1;

    // result kind
    localparam logic KIND_CHUNK   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_PAST_END    = 3'd1,
        ERR_NAME_LONG   = 3'd2,
        ERR_LABEL_PAST  = 3'd3,
        ERR_FIXED_SHORT = 3'd4,
        ERR_RDATA_SHORT = 3'd5,
        ERR_HOP_LIMIT   = 3'd6
    } err_code_t;

    typedef struct packed {
        logic      start;
        logic      store_wr;
        logic      len_rd;
        logic      dot_wr;
        logic      ptr_take;
        logic      ptr_jump;
        logic      lab_take;
        logic      lab_step;
        logic      name_end;
        logic      fix_start;
        logic      fix_step;
        logic      chunk_start;
        logic      chunk_step;
        logic      out_chunk;
        logic      out_sum;
        logic      out_err;
        err_code_t err;
    } cmd_t;

    typedef struct packed {
        logic pos_ge_lim;
        logic b_zero;
        logic b_ptr;
        logic dot_pend;
        logic hop_max;
        logic name_long;
        logic label_past;
        logic fix_short;
        logic rdata_short;
        logic fetch_done;
        logic name_done;
        logic out_free;
    } sts_t;

endpackage

[hdl/drp_ram.sv]
// drp_ram: generic single-clock ram, one write port and one read port
// read data is registered; no reset on the contents
// depends on nothing

module drp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

[hdl/drp_datapath.sv]
// drp_datapath: packet store, name buffer, walk registers and result register
// depends on drp_pkg and drp_ram; driven by drp_ctrl through cmd_t, reports through sts_t

module drp_datapath #(
    parameter int PACKET_BYTES = drp_pkg::PACKET_BYTES_DEF,
    parameter int NAME_LIMIT   = drp_pkg::NAME_LIMIT_DEF,
    parameter int MAX_HOPS     = drp_pkg::MAX_HOPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  drp_pkg::cmd_t                 cmd,
    output drp_pkg::sts_t                 sts,
    input  logic [drp_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [drp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    import drp_pkg::*;

    localparam int AW  = $clog2(PACKET_BYTES);
    localparam int NAW = (NAME_LIMIT > 1) ? $clog2(NAME_LIMIT) : 1;
    localparam int HW  = $clog2(MAX_HOPS + 1);
    localparam int CW  = NAW + 9;
    localparam int RW  = NAW + 4;
    localparam int PW1 = POS_W + 1;

    // input fields
    logic [8:0]       in_addr;
    logic [7:0]       in_value;
    logic [START_W-1:0] in_start;
    logic [LIM_W-1:0] in_len;

    assign in_addr  = s_tdata[8:0];
    assign in_value = s_tdata[16:9];
    assign in_start = s_tdata[25:17];
    assign in_len   = s_tdata[35:26];

    // walk registers
    logic [LIM_W-1:0]   lim_reg, lim_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [NAW-1:0]     used_reg, used_next;
    logic [NAW-1:0]     idx_reg, idx_next;
    logic [HW-1:0]      hops_reg, hops_next;
    logic [5:0]         hi_reg, hi_next;
    logic               measure_reg, measure_next;
    logic               dot_pend_reg, dot_pend_next;
    logic [CNT_W-1:0]   fetch_cnt_reg, fetch_cnt_next;
    logic               fetch_vld_reg, fetch_vld_next;
    logic [79:0]        fix_reg, fix_next;
    logic [LIM_W-1:0]   rest_reg, rest_next;
    logic [63:0]        chunk_reg, chunk_next;
    logic [3:0]         nc_reg, nc_next;

    // result register
    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_kind_reg, m_kind_next;
    logic               m_last_reg, m_last_next;
    logic [63:0]        m_name_reg, m_name_next;
    logic [3:0]         m_count_reg, m_count_next;
    logic [15:0]        m_type_reg, m_type_next;
    logic [15:0]        m_class_reg, m_class_next;
    logic [31:0]        m_ttl_reg, m_ttl_next;
    logic [15:0]        m_rlen_reg, m_rlen_next;
    logic [9:0]         m_roff_reg, m_roff_next;
    logic [9:0]         m_cons_reg, m_cons_next;
    err_code_t          m_err_reg, m_err_next;

    // memories
    logic               pkt_we, pkt_re;
    logic [AW-1:0]      pkt_waddr, pkt_raddr;
    logic [7:0]         pkt_rdata;
    logic               name_we, name_re;
    logic [NAW-1:0]     name_waddr;
    logic [7:0]         name_wdata;
    logic [7:0]         name_rdata;

    logic               fetch_active;
    logic [SUM_W-1:0]   base_sum;
    logic [RW-1:0]      rem;
    logic               out_free;

    assign pkt_we    = cmd.store_wr && (32'(in_addr) < PACKET_BYTES);
    assign pkt_waddr = AW'(in_addr);
    assign pkt_raddr = AW'(pos_reg);
    assign fetch_active = (fetch_cnt_reg != '0);
    assign pkt_re    = cmd.len_rd || cmd.ptr_take
                     || ((cmd.lab_step || cmd.fix_step) && fetch_active);

    assign name_re    = cmd.chunk_step && fetch_active;
    assign name_we    = cmd.dot_wr || (cmd.lab_step && fetch_vld_reg);
    assign name_waddr = used_reg;
    assign name_wdata = cmd.dot_wr ? DOT_CHAR : pkt_rdata;

    assign base_sum = SUM_W'(start_reg) + SUM_W'(total_reg) + SUM_W'(FIXED_PART);
    assign rem      = RW'(used_reg) - RW'(idx_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    drp_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_packet_store (
        .aclk    (aclk),
        .wr_en   (pkt_we),
        .wr_addr (pkt_waddr),
        .wr_data (in_value),
        .rd_en   (pkt_re),
        .rd_addr (pkt_raddr),
        .rd_data (pkt_rdata)
    );

    drp_ram #(.WIDTH(8), .DEPTH(NAME_LIMIT)) u_name_buf (
        .aclk    (aclk),
        .wr_en   (name_we),
        .wr_addr (name_waddr),
        .wr_data (name_wdata),
        .rd_en   (name_re),
        .rd_addr (idx_reg),
        .rd_data (name_rdata)
    );

    // status towards the controller
    always_comb begin
        sts.pos_ge_lim  = pos_reg >= POS_W'(lim_reg);
        sts.b_zero      = pkt_rdata == 8'd0;
        sts.b_ptr       = (pkt_rdata & PTR_FLAGS) == PTR_FLAGS;
        sts.dot_pend    = dot_pend_reg;
        sts.hop_max     = 32'(hops_reg) >= MAX_HOPS;
        sts.name_long   = (CW'(used_reg) + CW'(pkt_rdata) + CW'(1)) >= CW'(NAME_LIMIT);
        sts.label_past  = (PW1'(pos_reg) + PW1'(pkt_rdata)) >= PW1'(lim_reg);
        sts.fix_short   = base_sum > SUM_W'(lim_reg);
        sts.rdata_short = 16'(rest_reg) < fix_reg[15:0];
        sts.fetch_done  = !fetch_active && !fetch_vld_reg;
        sts.name_done   = idx_reg == used_reg;
        sts.out_free    = out_free;
    end

    always_comb begin
        lim_next       = lim_reg;
        start_next     = start_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        hops_next      = hops_reg;
        hi_next        = hi_reg;
        measure_next   = measure_reg;
        dot_pend_next  = dot_pend_reg;
        fetch_cnt_next = fetch_cnt_reg;
        fetch_vld_next = fetch_vld_reg;
        fix_next       = fix_reg;
        rest_next      = rest_reg;
        chunk_next     = chunk_reg;
        nc_next        = nc_reg;

        if (cmd.start) begin
            start_next    = in_start;
            lim_next      = (32'(in_len) > PACKET_BYTES) ? LIM_W'(PACKET_BYTES) : in_len;
            pos_next      = POS_W'(in_start);
            total_next    = '0;
            used_next     = '0;
            idx_next      = '0;
            hops_next     = '0;
            measure_next  = 1'b1;
            dot_pend_next = 1'b0;
        end

        if (cmd.len_rd) begin
            pos_next = pos_reg + POS_W'(1);
        end

        if (cmd.dot_wr) begin
            used_next     = used_reg + NAW'(1);
            dot_pend_next = 1'b0;
        end

        if (cmd.ptr_take) begin
            pos_next  = pos_reg + POS_W'(1);
            hops_next = hops_reg + HW'(1);
            hi_next   = pkt_rdata[5:0] & PTR_HIGH_MASK[5:0];
            if (measure_reg) begin
                total_next = total_reg + TOTAL_W'(2);
            end
        end

        if (cmd.ptr_jump) begin
            pos_next     = POS_W'({hi_reg, pkt_rdata});
            measure_next = 1'b0;
        end

        if (cmd.lab_take) begin
            fetch_cnt_next = pkt_rdata;
            fetch_vld_next = 1'b0;
            dot_pend_next  = 1'b1;
            if (measure_reg) begin
                total_next = total_reg + TOTAL_W'(pkt_rdata) + TOTAL_W'(1);
            end
        end

        if (cmd.name_end && measure_reg) begin
            total_next = total_reg + TOTAL_W'(1);
        end

        if (cmd.fix_start) begin
            pos_next       = POS_W'(SUM_W'(start_reg) + SUM_W'(total_reg));
            rest_next      = LIM_W'(SUM_W'(lim_reg) - base_sum);
            fetch_cnt_next = CNT_W'(FIXED_PART);
            fetch_vld_next = 1'b0;
        end

        if (cmd.lab_step || cmd.fix_step) begin
            if (fetch_active) begin
                pos_next       = pos_reg + POS_W'(1);
                fetch_cnt_next = fetch_cnt_reg - CNT_W'(1);
            end
            fetch_vld_next = fetch_active;
        end

        if (cmd.lab_step && fetch_vld_reg) begin
            used_next = used_reg + NAW'(1);
        end

        if (cmd.fix_step && fetch_vld_reg) begin
            fix_next = {fix_reg[71:0], pkt_rdata};
        end

        if (cmd.chunk_start) begin
            fetch_cnt_next = (rem >= RW'(CHUNK_BYTES)) ? CNT_W'(CHUNK_BYTES) : CNT_W'(rem);
            fetch_vld_next = 1'b0;
            chunk_next     = '0;
            nc_next        = '0;
        end

        if (cmd.chunk_step) begin
            if (fetch_active) begin
                idx_next       = idx_reg + NAW'(1);
                fetch_cnt_next = fetch_cnt_reg - CNT_W'(1);
            end
            fetch_vld_next = fetch_active;
            if (fetch_vld_reg) begin
                chunk_next[nc_reg[2:0]*8 +: 8] = name_rdata;
                nc_next = nc_reg + 4'd1;
            end
        end
    end

    // result register loads
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_last_next   = m_last_reg;
        m_name_next   = m_name_reg;
        m_count_next  = m_count_reg;
        m_type_next   = m_type_reg;
        m_class_next  = m_class_reg;
        m_ttl_next    = m_ttl_reg;
        m_rlen_next   = m_rlen_reg;
        m_roff_next   = m_roff_reg;
        m_cons_next   = m_cons_reg;
        m_err_next    = m_err_reg;

        if (cmd.out_chunk || cmd.out_sum || cmd.out_err) begin
            m_tvalid_next = 1'b1;
            m_kind_next   = KIND_SUMMARY;
            m_last_next   = 1'b1;
            m_name_next   = '0;
            m_count_next  = '0;
            m_type_next   = '0;
            m_class_next  = '0;
            m_ttl_next    = '0;
            m_rlen_next   = '0;
            m_roff_next   = '0;
            m_cons_next   = '0;
            m_err_next    = ERR_NONE;
            if (cmd.out_chunk) begin
                m_kind_next  = KIND_CHUNK;
                m_last_next  = 1'b0;
                m_name_next  = chunk_reg;
                m_count_next = nc_reg;
            end else if (cmd.out_sum) begin
                m_type_next  = fix_reg[79:64];
                m_class_next = fix_reg[63:48];
                m_ttl_next   = fix_reg[47:16];
                m_rlen_next  = fix_reg[15:0];
                m_roff_next  = 10'(pos_reg);
                m_cons_next  = 10'(17'(total_reg) + 17'(FIXED_PART) + 17'(fix_reg[15:0]));
            end else begin
                m_err_next = cmd.err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg  <= 1'b0;
            fetch_cnt_reg <= '0;
            fetch_vld_reg <= 1'b0;
            used_reg      <= '0;
            idx_reg       <= '0;
            dot_pend_reg  <= 1'b0;
        end else begin
            m_tvalid_reg  <= m_tvalid_next;
            fetch_cnt_reg <= fetch_cnt_next;
            fetch_vld_reg <= fetch_vld_next;
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            dot_pend_reg  <= dot_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        lim_reg     <= lim_next;
        start_reg   <= start_next;
        pos_reg     <= pos_next;
        total_reg   <= total_next;
        hops_reg    <= hops_next;
        hi_reg      <= hi_next;
        measure_reg <= measure_next;
        fix_reg     <= fix_next;
        rest_reg    <= rest_next;
        chunk_reg   <= chunk_next;
        nc_reg      <= nc_next;
        m_kind_reg  <= m_kind_next;
        m_last_reg  <= m_last_next;
        m_name_reg  <= m_name_next;
        m_count_reg <= m_count_next;
        m_type_reg  <= m_type_next;
        m_class_reg <= m_class_next;
        m_ttl_reg   <= m_ttl_next;
        m_rlen_reg  <= m_rlen_next;
        m_roff_reg  <= m_roff_next;
        m_cons_reg  <= m_cons_next;
        m_err_reg   <= m_err_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'd0, m_err_reg, m_cons_reg, m_roff_reg, m_rlen_reg, m_ttl_reg,
                       m_class_reg, m_type_reg, m_count_reg, m_name_reg};

    // chunk transfers carry one to eight characters
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_kind_reg == KIND_CHUNK) |-> (m_count_reg != 4'd0 && m_count_reg <= 4'd8))
        else $error("name chunk with bad character count");

    // an error result stands alone and carries nothing else
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_err_reg != ERR_NONE)
            |-> (m_kind_reg == KIND_SUMMARY && m_last_reg && m_name_reg == '0))
        else $error("error result with stray fields");

    // the result register is only loaded when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_chunk || cmd.out_sum || cmd.out_err) |-> out_free)
        else $error("result register overwritten");

    // the chunk read index never runs past the buffered name
    assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= used_reg)
        else $error("name read index past name length");

endmodule

[hdl/drp_ctrl.sv]
// drp_ctrl: sequencing state machine for the dns record parser
// walks the name, fixed part and chunk output by issuing cmd_t to drp_datapath
// depends on drp_pkg

module drp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_tuser,
    input  drp_pkg::sts_t sts,
    output drp_pkg::cmd_t cmd
);

    import drp_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_LEN_CHK  = 13'b0000000000010,
        S_LEN_EVAL = 13'b0000000000100,
        S_PTR_EVAL = 13'b0000000001000,
        S_LAB      = 13'b0000000010000,
        S_FIX_CHK  = 13'b0000000100000,
        S_FIX_RD   = 13'b0000001000000,
        S_RLEN_CHK = 13'b0000010000000,
        S_CH_START = 13'b0000100000000,
        S_CH_RD    = 13'b0001000000000,
        S_CH_PUSH  = 13'b0010000000000,
        S_SUM      = 13'b0100000000000,
        S_ERR      = 13'b1000000000000
    } state_t;

    state_t    state_reg, state_next;
    err_code_t err_reg, err_next;
    logic      accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        err_next   = err_reg;
        cmd        = '0;
        cmd.err    = err_reg;

        case (state_reg)
            S_IDLE: begin
                cmd.store_wr = accept && (s_tuser == ACT_WRITE);
                cmd.start    = accept && (s_tuser == ACT_PARSE);
                if (cmd.start) begin
                    state_next = S_LEN_CHK;
                end
            end
            S_LEN_CHK: begin
                if (sts.pos_ge_lim) begin
                    err_next   = ERR_PAST_END;
                    state_next = S_ERR;
                end else begin
                    cmd.len_rd = 1'b1;
                    state_next = S_LEN_EVAL;
                end
            end
            S_LEN_EVAL: begin
                if (sts.b_zero) begin
                    cmd.name_end = 1'b1;
                    state_next   = S_FIX_CHK;
                end else if (sts.dot_pend) begin
                    cmd.dot_wr = 1'b1;
                end else if (sts.b_ptr) begin
                    if (sts.pos_ge_lim) begin
                        err_next   = ERR_PAST_END;
                        state_next = S_ERR;
                    end else if (sts.hop_max) begin
                        err_next   = ERR_HOP_LIMIT;
                        state_next = S_ERR;
                    end else begin
                        cmd.ptr_take = 1'b1;
                        state_next   = S_PTR_EVAL;
                    end
                end else if (sts.name_long) begin
                    err_next   = ERR_NAME_LONG;
                    state_next = S_ERR;
                end else if (sts.label_past) begin
                    err_next   = ERR_LABEL_PAST;
                    state_next = S_ERR;
                end else begin
                    cmd.lab_take = 1'b1;
                    state_next   = S_LAB;
                end
            end
            S_PTR_EVAL: begin
                cmd.ptr_jump = 1'b1;
                state_next   = S_LEN_CHK;
            end
            S_LAB: begin
                cmd.lab_step = 1'b1;
                if (sts.fetch_done) begin
                    state_next = S_LEN_CHK;
                end
            end
            S_FIX_CHK: begin
                if (sts.fix_short) begin
                    err_next   = ERR_FIXED_SHORT;
                    state_next = S_ERR;
                end else begin
                    cmd.fix_start = 1'b1;
                    state_next    = S_FIX_RD;
                end
            end
            S_FIX_RD: begin
                cmd.fix_step = 1'b1;
                if (sts.fetch_done) begin
                    state_next = S_RLEN_CHK;
                end
            end
            S_RLEN_CHK: begin
                if (sts.rdata_short) begin
                    err_next   = ERR_RDATA_SHORT;
                    state_next = S_ERR;
                end else begin
                    state_next = S_CH_START;
                end
            end
            S_CH_START: begin
                if (sts.name_done) begin
                    state_next = S_SUM;
                end else begin
                    cmd.chunk_start = 1'b1;
                    state_next      = S_CH_RD;
                end
            end
            S_CH_RD: begin
                cmd.chunk_step = 1'b1;
                if (sts.fetch_done) begin
                    state_next = S_CH_PUSH;
                end
            end
            S_CH_PUSH: begin
                if (sts.out_free) begin
                    cmd.out_chunk = 1'b1;
                    state_next    = S_CH_START;
                end
            end
            S_SUM: begin
                if (sts.out_free) begin
                    cmd.out_sum = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_ERR: begin
                if (sts.out_free) begin
                    cmd.out_err = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            err_reg   <= ERR_NONE;
        end else begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    // an error result always comes from the error state with a real code
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_err |-> (state_reg == S_ERR && err_reg != ERR_NONE))
        else $error("error result without error code");

    // a parse request always starts the walk with the bounds check
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (state_reg == S_LEN_CHK))
        else $error("parse request did not start the name walk");

endmodule

[hdl/dns_record_parser.sv]
// dns_record_parser: top level, dns resource record parser with name decompression
// joins drp_ctrl and drp_datapath; depends on drp_pkg
//
//  channel | dir | handshake          | tdata / tuser / tlast
//  s_      | in  | s_tvalid, s_tready | byte write or parse request, tuser = action
//  m_      | out | m_tvalid, m_tready | name chunk or record summary, tuser = kind, tlast = last
//
// the store has one read port, so labels and the fixed part are read one byte a cycle:
// a parse checks each length byte, takes each label or pointer, reads the fixed part,
// then sends the name in 8-character chunks, each held while the result side is busy, then the summary
// the result register decouples the sides; a new transfer is taken once the summary is loaded
// reset clears control state only; the packet store holds no value until written
// a stalled result side holds the parse in its output state, no result is dropped

module dns_record_parser #(
    parameter int PACKET_BYTES = drp_pkg::PACKET_BYTES_DEF,
    parameter int NAME_LIMIT   = drp_pkg::NAME_LIMIT_DEF,
    parameter int MAX_HOPS     = drp_pkg::MAX_HOPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // byte_address, byte_value, start_offset, packet_len
    input  logic [drp_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // name_bytes, name_count, record_type, record_class, time_to_live,
    // rdata_length, rdata_offset, consumed, error_code
    output logic [drp_pkg::M_TDATA_W-1:0] m_tdata,
    // kind
    output logic                          m_tuser,
    output logic                          m_tlast
);

    import drp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    drp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    drp_datapath #(
        .PACKET_BYTES (PACKET_BYTES),
        .NAME_LIMIT   (NAME_LIMIT),
        .MAX_HOPS     (MAX_HOPS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[bench/dns_record_parser_tb.sv]
`timescale 1ns / 100ps
// dns_record_parser_tb: self-checking bench for the dns record parser, preloads the packet store,
// runs directed records then random records with compression pointers, checks every result
// depends on drp_pkg and dns_record_parser

module dns_record_parser_tb;
    import drp_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 400;
    localparam int ITEM_TARGET   = 180;
    localparam int PARSE_TARGET  = 60;
    localparam int RECORD_SPAN   = 112;

    typedef logic [7:0] octet_q[$];

    typedef struct packed {
        logic        kind;
        logic [63:0] name_bytes;
        logic [3:0]  name_count;
        logic [15:0] record_type;
        logic [15:0] record_class;
        logic [31:0] time_to_live;
        logic [15:0] rdata_length;
        logic [9:0]  rdata_offset;
        logic [9:0]  consumed;
        err_code_t   err;
        logic        last;
    } parse_result_t;

    class parse_result_board;
        logic [7:0]    packet_copy [0:PACKET_BYTES_DEF-1];
        parse_result_t awaited_results[$];
        int            mismatches;
        int            writes_seen;
        int            parses_seen;
        int            chunks_seen;
        int            summaries_seen;
        int            longest_name;
        logic [7:0]    errors_seen;

        function int peek(int addr);
            return (addr < PACKET_BYTES_DEF) ? int'(packet_copy[addr]) : 0;
        endfunction

        function void expect_error(err_code_t code);
            parse_result_t r;
            r = '0;
            r.kind = KIND_SUMMARY;
            r.err = code;
            r.last = 1'b1;
            awaited_results.push_back(r);
        endfunction

        // walks the owner name with pointer following, then the fixed part and rdata
        function void walk_record(int start, int plen);
            logic [7:0]    name_buf [0:NAME_LIMIT_DEF-1];
            int            lim, pos, b, total, used, hops, rest, base, rlen, n;
            bit            measure;
            logic [63:0]   word;
            parse_result_t r;
            total = 0;
            used = 0;
            hops = 0;
            measure = 1'b1;
            lim = (plen > PACKET_BYTES_DEF) ? PACKET_BYTES_DEF : plen;
            pos = start;
            while (1) begin
                if (pos >= lim) begin
                    expect_error(ERR_PAST_END);
                    return;
                end
                b = peek(pos);
                pos++;
                if (b == 0)
                    break;
                if (measure)
                    total++;
                if ((b & PTR_FLAGS) == PTR_FLAGS) begin
                    if (pos >= lim) begin
                        expect_error(ERR_PAST_END);
                        return;
                    end
                    if (measure)
                        total++;
                    if (hops >= MAX_HOPS_DEF) begin
                        expect_error(ERR_HOP_LIMIT);
                        return;
                    end
                    hops++;
                    pos = ((b & PTR_HIGH_MASK) << 8) | peek(pos);
                    measure = 1'b0;
                    continue;
                end
                if (used + b + 1 >= NAME_LIMIT_DEF) begin
                    expect_error(ERR_NAME_LONG);
                    return;
                end
                if (pos + b >= lim) begin
                    expect_error(ERR_LABEL_PAST);
                    return;
                end
                for (int i = 0; i < b; i++)
                    name_buf[used + i] = packet_copy[pos + i];
                pos += b;
                used += b;
                if (measure)
                    total += b;
                if (peek(pos) != 0) begin
                    name_buf[used] = DOT_CHAR;
                    used++;
                end
            end
            if (measure)
                total++;

            rest = lim - (start + total + FIXED_PART);
            if (rest < 0) begin
                expect_error(ERR_FIXED_SHORT);
                return;
            end
            base = start + total;
            rlen = (peek(base + 8) << 8) | peek(base + 9);
            if (rest < rlen) begin
                expect_error(ERR_RDATA_SHORT);
                return;
            end

            if (used > longest_name)
                longest_name = used;
            for (int i = 0; i < used; i += CHUNK_BYTES) begin
                n = (used - i > CHUNK_BYTES) ? CHUNK_BYTES : used - i;
                word = '0;
                for (int j = 0; j < n; j++)
                    word[8*j +: 8] = name_buf[i + j];
                r = '0;
                r.kind = KIND_CHUNK;
                r.name_bytes = word;
                r.name_count = n;
                awaited_results.push_back(r);
            end
            r = '0;
            r.kind = KIND_SUMMARY;
            r.record_type = (peek(base) << 8) | peek(base + 1);
            r.record_class = (peek(base + 2) << 8) | peek(base + 3);
            r.time_to_live = (peek(base + 4) << 24) | (peek(base + 5) << 16) |
                             (peek(base + 6) << 8) | peek(base + 7);
            r.rdata_length = rlen;
            r.rdata_offset = base + FIXED_PART;
            r.consumed = total + FIXED_PART + rlen;
            r.err = ERR_NONE;
            r.last = 1'b1;
            awaited_results.push_back(r);
        endfunction

        function void note_request(logic act, logic [8:0] addr, logic [7:0] val,
                                   logic [8:0] start, logic [9:0] plen);
            if (act == ACT_WRITE) begin
                packet_copy[addr] = val;
                writes_seen++;
            end else begin
                parses_seen++;
                walk_record(start, plen);
            end
        endfunction

        function bit field_differs(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                if (mismatches < 10)
                    $display("%t: %s expected %h got %h", $realtime, field, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_result(logic kind, logic [M_TDATA_W-1:0] data, logic last);
            parse_result_t want, got;
            bit            bad;
            got.kind = kind;
            got.name_bytes = data[63:0];
            got.name_count = data[67:64];
            got.record_type = data[83:68];
            got.record_class = data[99:84];
            got.time_to_live = data[131:100];
            got.rdata_length = data[147:132];
            got.rdata_offset = data[157:148];
            got.consumed = data[167:158];
            got.err = err_code_t'(data[170:168]);
            got.last = last;
            if (awaited_results.size() == 0) begin
                if (mismatches < 10)
                    $display("%t: result with none awaited, kind %b tdata %h",
                             $realtime, kind, data);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            bad = 1'b0;
            bad |= field_differs("kind", want.kind, got.kind);
            bad |= field_differs("name_bytes", want.name_bytes, got.name_bytes);
            bad |= field_differs("name_count", want.name_count, got.name_count);
            bad |= field_differs("record_type", want.record_type, got.record_type);
            bad |= field_differs("record_class", want.record_class, got.record_class);
            bad |= field_differs("time_to_live", want.time_to_live, got.time_to_live);
            bad |= field_differs("rdata_length", want.rdata_length, got.rdata_length);
            bad |= field_differs("rdata_offset", want.rdata_offset, got.rdata_offset);
            bad |= field_differs("consumed", want.consumed, got.consumed);
            bad |= field_differs("error_code", want.err, got.err);
            bad |= field_differs("last", want.last, got.last);
            if (bad)
                mismatches++;
            if (want.kind == KIND_CHUNK)
                chunks_seen++;
            else if (want.err == ERR_NONE)
                summaries_seen++;
            else
                errors_seen[want.err] = 1'b1;
        endfunction

        function void close_out();
            if (awaited_results.size() != 0) begin
                $display("%0d results never arrived", awaited_results.size());
                mismatches += awaited_results.size();
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = ACT_WRITE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    parse_result_board board;
    octet_q            seq;
    int                name_starts[$];
    int                items_sent   = 0;
    int                quiet_cycles = 0;
    int                stall_left   = 0;
    bit                calm         = 1'b0;
    bit                tx_jitter    = 1'b1;
    bit                rx_jitter    = 1'b1;

    always #5 aclk = ~aclk;

    dns_record_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // result side: check each transfer, stall in bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready)
                board.check_result(m_tuser, m_tdata, m_tlast);
            if ($urandom_range(0, 199) == 0)
                rx_jitter <= !rx_jitter;
            if (calm || !rx_jitter) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if ($urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                stall_left <= $urandom_range(0, 11);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("no transfer for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic push_item(input logic act, input logic [8:0] addr, input logic [7:0] val,
                             input logic [8:0] start, input logic [9:0] plen);
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {4'b0, plen, start, val, addr};
        do
            @(posedge aclk);
        while (!s_tready);
        board.note_request(act, addr, val, start, plen);
        items_sent++;
        if (!calm && tx_jitter && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic write_byte(input int addr, input int val);
        push_item(ACT_WRITE, addr, val, $urandom_range(0, 511), $urandom_range(0, 1023));
    endtask

    task automatic parse_at(input int start, input int plen);
        push_item(ACT_PARSE, $urandom_range(0, 511), $urandom_range(0, 255), start, plen);
    endtask

    task automatic put_seq(input int at);
        foreach (seq[i])
            write_byte(at + i, seq[i]);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.awaited_results.size() != 0)
            @(posedge aclk);
    endtask

    // labels keep whatever content the store holds; only length bytes and fields are written
    task automatic build_record(input int at, output int rec_end);
        int pos, len, rdl, tgt;
        pos = at;
        repeat ($urandom_range(0, 4)) begin
            len = $urandom_range(1, 20);
            write_byte(pos, len);
            pos += len + 1;
        end
        if (name_starts.size() != 0 && $urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 7) == 0)
                tgt = $urandom_range(0, 16383);
            else
                tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
            write_byte(pos, PTR_FLAGS | (tgt >> 8));
            write_byte(pos + 1, tgt & 8'hff);
            pos += 2;
        end else begin
            write_byte(pos, 0);
            pos++;
        end
        name_starts.push_back(at);
        rdl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 16);
        for (int i = 0; i < 8; i++)
            write_byte(pos + i, $urandom_range(0, 255));
        write_byte(pos + 8, rdl >> 8);
        write_byte(pos + 9, rdl & 8'hff);
        pos += FIXED_PART;
        rec_end = (rdl <= 16) ? pos + rdl : pos;
    endtask

    initial begin : main_flow
        int at, rec_end, plen, item_base, parse_base;
        board = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int a = 0; a < PACKET_BYTES_DEF; a++)
            write_byte(a, $urandom_range(0, 255));

        // plain name, then a label with a pointer into it, then a trailing dot
        seq = '{8'h03, 8'h77, 8'h77, 8'h77, 8'h02, 8'h65, 8'h78, 8'h00,
                8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h0e, 8'h10, 8'h00, 8'h04,
                8'hc0, 8'ha8, 8'h00, 8'h01,
                8'h04, 8'h6d, 8'h61, 8'h69, 8'h6c, 8'hc0, 8'h04,
                8'h00, 8'h0f, 8'h00, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00,
                8'h01, 8'h61, 8'hc0, 8'h07,
                8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc, 8'hde, 8'hf0, 8'h00, 8'h00,
                8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00};
        put_seq(0);
        // reserved length byte as a 64 byte label, a self pointer, and an overlong name
        write_byte(64, 8'h40);
        write_byte(129, 8'h00);
        for (int i = 130; i < 138; i++)
            write_byte(i, $urandom_range(0, 255));
        write_byte(138, 8'h00);
        write_byte(139, 8'h00);
        write_byte(140, PTR_FLAGS);
        write_byte(141, 8'h8c);
        write_byte(142, 8'hbf);
        write_byte(334, 8'h40);
        write_byte(399, 8'h00);

        parse_at(0, 22);
        parse_at(0, 1023);
        parse_at(0, 21);
        parse_at(0, 17);
        parse_at(0, 5);
        parse_at(0, 0);
        parse_at(22, 39);
        parse_at(39, 53);
        parse_at(53, 64);
        parse_at(64, 140);
        parse_at(140, 512);
        parse_at(140, 141);
        parse_at(142, 512);
        parse_at(511, 512);
        parse_at(0, 512);

        // longest legal name: 191 and 62 character labels
        write_byte(334, 8'h3e);
        write_byte(397, 8'h00);
        for (int i = 398; i < 406; i++)
            write_byte(i, $urandom_range(0, 255));
        write_byte(406, 8'h00);
        write_byte(407, 8'h00);
        parse_at(142, 408);
        parse_at(142, 407);

        settle();

        item_base = items_sent;
        parse_base = board.parses_seen;
        while (items_sent - item_base < ITEM_TARGET || board.parses_seen - parse_base < PARSE_TARGET) begin
            calm = (items_sent - item_base >= ITEM_TARGET) &&
                   (board.parses_seen - parse_base >= PARSE_TARGET - 12);
            tx_jitter = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                write_byte($urandom_range(0, 511), $urandom_range(0, 255));
            at = $urandom_range(0, PACKET_BYTES_DEF - 1 - RECORD_SPAN);
            build_record(at, rec_end);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: parse_at(at, rec_end);
                    6, 7: begin
                        plen = rec_end + $urandom_range(0, 1023);
                        parse_at(at, (plen > 1023) ? 1023 : plen);
                    end
                    8: parse_at(at, $urandom_range(at, rec_end));
                    default: parse_at($urandom_range(0, 511), $urandom_range(0, 1023));
                endcase
            end
        end
        calm = 1'b1;

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        board.close_out();

        $display("covered %0d byte writes and %0d parse requests, longest name %0d characters",
                 board.writes_seen, board.parses_seen, board.longest_name);
        $display("checked %0d name chunks and %0d clean summaries, error codes seen %b",
                 board.chunks_seen, board.summaries_seen, board.errors_seen);
        if (board.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
